// File: design/sha1bs_pkg.sv
// shared types, constants and codes for the sha-1 byte stream hasher
// no dependencies; imported by sha1bs_compress and sha1_byte_stream_hasher_core

package sha1bs_pkg;

	localparam int unsigned WORD_W    = 32;
	localparam int unsigned NUM_H     = 5;
	localparam int unsigned BLK_WORDS = 16;
	localparam int unsigned ROUNDS    = 80;
	localparam int unsigned RND_W     = $clog2(ROUNDS);
	localparam int unsigned IDX_W     = $clog2(NUM_H);

	// initial chaining value, entry 0 is the first word
	localparam logic [NUM_H-1:0][WORD_W-1:0] H_INIT = {
		32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
	};

	localparam logic [WORD_W-1:0] K_0 = 32'h5a827999;
	localparam logic [WORD_W-1:0] K_1 = 32'h6ed9eba1;
	localparam logic [WORD_W-1:0] K_2 = 32'h8f1bbcdc;
	localparam logic [WORD_W-1:0] K_3 = 32'hca62c1d6;

	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam logic [5:0] LEN_POS    = 6'd56;
	localparam logic [5:0] BLK_LAST   = 6'd63;

	typedef enum logic [1:0] {
		CMD_APPEND     = 2'd0,
		CMD_APPEND_FIN = 2'd1,
		CMD_FINISH     = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_WAIT,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_ONE,
		PH_ZERO,
		PH_LEN
	} pad_ph_t;

	// sequencer to compression engine
	typedef struct packed {
		logic              word_push;
		logic [WORD_W-1:0] word;
		logic              load;
		logic              step;
		logic [RND_W-1:0]  rnd;
		logic              add;
		logic              init;
	} cmp_ctrl_t;

endpackage

// File: design/sha1bs_compress.sv
// sha-1 compression engine: schedule window, working variables, chaining value
// one round per step through a single shared round adder; uses sha1bs_pkg

module sha1bs_compress (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  sha1bs_pkg::cmp_ctrl_t                                ctrl,
	output logic [sha1bs_pkg::NUM_H-1:0][sha1bs_pkg::WORD_W-1:0] chain
);
	import sha1bs_pkg::*;

	logic [WORD_W-1:0] win_q [BLK_WORDS];
	logic [WORD_W-1:0] a_q, b_q, c_q, d_q, e_q;
	logic [NUM_H-1:0][WORD_W-1:0] chain_q;
	logic [WORD_W-1:0] mix, sched, f, k, t;

	// round function and schedule expansion
	always_comb begin
		mix   = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
		sched = {mix[WORD_W-2:0], mix[WORD_W-1]};
		if (ctrl.rnd < RND_W'(20)) begin
			f = ((c_q ^ d_q) & b_q) ^ d_q;
			k = K_0;
		end else if (ctrl.rnd < RND_W'(40)) begin
			f = b_q ^ c_q ^ d_q;
			k = K_1;
		end else if (ctrl.rnd < RND_W'(60)) begin
			f = (b_q & c_q) | (d_q & (b_q | c_q));
			k = K_2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K_3;
		end
		t = {a_q[WORD_W-6:0], a_q[WORD_W-1:WORD_W-5]} + f + e_q + win_q[0] + k;
	end

	// window doubles as the block buffer while bytes come in
	always_ff @(posedge clk) begin
		if (ctrl.word_push || ctrl.step) begin
			for (int i = 0; i < BLK_WORDS - 1; i++)
				win_q[i] <= win_q[i+1];
			win_q[BLK_WORDS-1] <= ctrl.step ? sched : ctrl.word;
		end
		if (ctrl.load) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (ctrl.step) begin
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[WORD_W-1:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= H_INIT;
		end else if (ctrl.init) begin
			chain_q <= H_INIT;
		end else if (ctrl.add) begin
			chain_q[0] <= chain_q[0] + a_q;
			chain_q[1] <= chain_q[1] + b_q;
			chain_q[2] <= chain_q[2] + c_q;
			chain_q[3] <= chain_q[3] + d_q;
			chain_q[4] <= chain_q[4] + e_q;
		end
	end

	assign chain = chain_q;

endmodule

// File: design/sha1_byte_stream_hasher_core.sv
// top level of the sha-1 byte stream hasher: byte packing, padding sequencer,
// length counter and digest output; uses sha1bs_pkg and sha1bs_compress
//
// usage
//   input request: cmd and data_byte, taken when in_valid is high and in_stall low.
//   cmd append adds data_byte to the message, append-and-finish adds it and then
//   closes the message, finish closes it without a byte; the unused code is taken
//   and dropped. output requests are the five digest words, most significant
//   first, with word_index 0..4 and last_word on the fifth.
// timing
//   the byte that completes a 64-byte block keeps in_stall high while the single
//   round adder runs the rounds of the block, one round per cycle, before new input
//   is taken. a finish then issues one padding byte per cycle while no compression
//   runs (0x80, zeros, eight length bytes, with a step that pushes nothing
//   before the length), runs one or two compressions, passes through the wait
//   state for the chaining add and offers the five words, one per cycle when
//   out_stall is low.
// stall and reset
//   while out_stall is high the current digest word and its tags hold, and no
//   input is taken until the fifth word has gone. after the fifth word the block
//   is back at the initial hash value, ready for a new message.
//   arst_n low returns the block to idle with the initial hash value and a zero
//   length; no clearing pass is needed.

module sha1_byte_stream_hasher_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import sha1bs_pkg::*;

	state_t  state_q, state_d;
	pad_ph_t ph_q, ph_d;

	logic             fin_q;       // message is being closed
	logic             last_q;      // block in flight holds the length
	logic             add_pend_q;  // chaining add due this cycle
	logic [2:0]       len_cnt_q;   // length bytes sent
	logic [RND_W-1:0] rnd_q;
	logic [5:0]       cnt_q;       // bytes held in the current block
	logic [63:0]      len_q;       // message length in bits
	logic [IDX_W-1:0] out_idx_q;
	logic [23:0]      acc_q;       // partial word, newest byte lowest

	// sequencer decisions
	logic       push;
	logic [7:0] push_byte;
	logic       take;
	logic       fin_set;
	logic       len_shift;
	logic       last_set;
	logic       step;
	logic       round_end;
	logic       out_take;
	logic       clr;
	logic       cnt_full;

	cmp_ctrl_t                    ctrl;
	logic [NUM_H-1:0][WORD_W-1:0] chain;

	assign cnt_full = (cnt_q == BLK_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ph_d      = ph_q;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		push      = 1'b0;
		push_byte = 8'h00;
		take      = 1'b0;
		fin_set   = 1'b0;
		len_shift = 1'b0;
		last_set  = 1'b0;
		step      = 1'b0;
		round_end = 1'b0;
		out_take  = 1'b0;
		clr       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (cmd == CMD_APPEND || cmd == CMD_APPEND_FIN) begin
						push      = 1'b1;
						push_byte = data_byte;
						take      = 1'b1;
					end
					if (cmd == CMD_APPEND_FIN || cmd == CMD_FINISH) begin
						fin_set = 1'b1;
						ph_d    = PH_ONE;
					end
				end
				if (push && cnt_full)
					state_d = ST_ROUND;
				else if (fin_set)
					state_d = ST_PAD;
			end
			ST_PAD: begin
				unique case (ph_q)
					PH_ONE: begin
						push      = 1'b1;
						push_byte = PAD_BYTE;
						ph_d      = PH_ZERO;
					end
					PH_ZERO: begin
						// zero fill stops where the length field begins
						if (cnt_q == LEN_POS)
							ph_d = PH_LEN;
						else
							push = 1'b1;
					end
					PH_LEN: begin
						push      = 1'b1;
						push_byte = len_q[63:56];
						len_shift = 1'b1;
						last_set  = (len_cnt_q == 3'd7);
					end
					default: ph_d = PH_ONE;
				endcase
				if (push && cnt_full)
					state_d = ST_ROUND;
			end
			ST_ROUND: begin
				step = 1'b1;
				if (rnd_q == RND_W'(ROUNDS - 1)) begin
					round_end = 1'b1;
					if (last_q)
						state_d = ST_WAIT;
					else if (fin_q)
						state_d = ST_PAD;
					else
						state_d = ST_IDLE;
				end
			end
			ST_WAIT: state_d = ST_OUT;
			ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					out_take = 1'b1;
					if (out_idx_q == IDX_W'(NUM_H - 1)) begin
						clr     = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q       <= PH_ONE;
			fin_q      <= 1'b0;
			last_q     <= 1'b0;
			add_pend_q <= 1'b0;
			len_cnt_q  <= 3'd0;
			rnd_q      <= '0;
			cnt_q      <= 6'd0;
			len_q      <= 64'd0;
			out_idx_q  <= '0;
		end else begin
			ph_q       <= ph_d;
			add_pend_q <= round_end;
			if (push)
				cnt_q <= cnt_q + 6'd1;
			if (take)
				len_q <= len_q + 64'd8;
			else if (len_shift)
				len_q <= {len_q[55:0], 8'h00};
			else if (clr)
				len_q <= 64'd0;
			if (fin_set) begin
				fin_q     <= 1'b1;
				len_cnt_q <= 3'd0;
			end else if (len_shift) begin
				len_cnt_q <= len_cnt_q + 3'd1;
			end
			if (last_set)
				last_q <= 1'b1;
			if (clr) begin
				fin_q  <= 1'b0;
				last_q <= 1'b0;
			end
			if (step)
				rnd_q <= round_end ? '0 : rnd_q + RND_W'(1);
			if (out_take)
				out_idx_q <= clr ? '0 : out_idx_q + IDX_W'(1);
		end
	end

	// byte packing, big-endian within each word
	always_ff @(posedge clk) begin
		if (push)
			acc_q <= {acc_q[15:0], push_byte};
	end

	always_comb begin
		ctrl.word_push = push && (cnt_q[1:0] == 2'b11);
		ctrl.word      = {acc_q, push_byte};
		ctrl.load      = push && cnt_full;
		ctrl.step      = step;
		ctrl.rnd       = rnd_q;
		ctrl.add       = add_pend_q;
		ctrl.init      = clr;
	end

	sha1bs_compress u_compress (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.chain  (chain)
	);

	assign digest_word = chain[out_idx_q];
	assign word_index  = out_idx_q;
	assign last_word   = (out_idx_q == IDX_W'(NUM_H - 1));

	// no input is taken while a digest is on offer
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && !in_stall))
		else $error("input taken while digest pending");

	a_rnd_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (rnd_q < RND_W'(ROUNDS)))
		else $error("round counter out of range");

	// the length block always ends on a block boundary
	a_out_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> (cnt_q == 6'd0))
		else $error("digest offered with bytes in block");

	a_clean_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_word) |=> (len_q == 64'd0 && !fin_q && !last_q))
		else $error("state not cleared after digest");

endmodule

// File: sim/tb_sha1_byte_stream_hasher_core.sv
// self-checking testbench for sha1_byte_stream_hasher_core: byte and finish requests in,
// digest words out, checked against a sha-1 predictor kept inside the bench
// depends on sha1bs_pkg and the core itself

module tb_sha1_byte_stream_hasher_core;
	import sha1bs_pkg::*;

	// the fourth command code has no name in the package; the core must drop it
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 2000000;
	localparam int unsigned HOLD_CYCLES = 500;
	localparam int unsigned TAIL_CYCLES = 400;

	typedef struct {
		logic [1:0] code;
		logic [7:0] data;
	} hash_req_t;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        is_last;
	} digest_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  cmd = CMD_FINISH;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	// request stream still to be offered, and digest words still owed by the core
	hash_req_t   pending_reqs[$];
	digest_res_t digest_due[$];

	// running sha-1 state of the message being absorbed
	logic [31:0] hash_state [5];
	logic [31:0] msg_words [16];
	logic [5:0]  fill_count;
	logic [63:0] bit_len;

	int unsigned cycle_count = 0;
	int unsigned total_reqs = 0;
	int unsigned accepted_reqs = 0;
	int unsigned msgs_queued = 0;
	int unsigned words_rcvd = 0;
	int unsigned mismatches = 0;
	int unsigned send_gap = 0;
	int unsigned recv_gap = 0;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;
	hash_req_t   next_req;
	digest_res_t due_word;

	sha1_byte_stream_hasher_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------------
	// sha-1 predictor
	// ---------------------------------------------------------------------

	function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
		return (x << n) | (x >> (32 - n));
	endfunction

	// back to the initial hash value with an empty block and zero length
	task automatic restart_message();
		for (int i = 0; i < 5; i++) hash_state[i] = H_INIT[i];
		for (int i = 0; i < 16; i++) msg_words[i] = 32'h0;
		fill_count = 6'd0;
		bit_len    = 64'd0;
	endtask

	// eighty rounds over the full block, then fold into the chaining value
	task automatic compress_block_words();
		logic [31:0] sched [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int r = 0; r < 16; r++) sched[r] = msg_words[r];
		for (int r = 16; r < 80; r++)
			sched[r] = rotl32(sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16], 1);
		a = hash_state[0];
		b = hash_state[1];
		c = hash_state[2];
		d = hash_state[3];
		e = hash_state[4];
		for (int r = 0; r < 80; r++) begin
			if (r < 20) begin
				f = ((c ^ d) & b) ^ d;
				k = K_0;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = K_1;
			end else if (r < 60) begin
				f = (b & c) | (d & (b | c));
				k = K_2;
			end else begin
				f = b ^ c ^ d;
				k = K_3;
			end
			t = rotl32(a, 5) + f + e + sched[r] + k;
			e = d;
			d = c;
			c = rotl32(b, 30);
			b = a;
			a = t;
		end
		hash_state[0] = hash_state[0] + a;
		hash_state[1] = hash_state[1] + b;
		hash_state[2] = hash_state[2] + c;
		hash_state[3] = hash_state[3] + d;
		hash_state[4] = hash_state[4] + e;
	endtask

	// bytes enter big-endian, from the low end of the current word
	task automatic push_msg_byte(input logic [7:0] b);
		logic [3:0] w;
		w = fill_count[5:2];
		msg_words[w] = {msg_words[w][23:0], b};
		fill_count = fill_count + 6'd1;
		if (fill_count == 6'd0) compress_block_words();
	endtask

	// one accepted request; a finish queues the five digest words it owes
	task automatic absorb_request(input logic [1:0] code, input logic [7:0] b);
		logic [63:0] len_bits;
		if (code == CMD_UNUSED) return;
		if (code == CMD_APPEND || code == CMD_APPEND_FIN) begin
			push_msg_byte(b);
			bit_len = bit_len + 64'd8;
		end
		if (code == CMD_APPEND) return;
		len_bits = bit_len;
		push_msg_byte(PAD_BYTE);
		while (fill_count != LEN_POS) push_msg_byte(8'h00);
		for (int i = 7; i >= 0; i--) push_msg_byte(len_bits[8*i +: 8]);
		for (int i = 0; i < 5; i++)
			digest_due.push_back('{word: hash_state[i], index: 3'(i), is_last: (i == 4)});
		restart_message();
	endtask

	// ---------------------------------------------------------------------
	// stimulus building
	// ---------------------------------------------------------------------

	task automatic add_req(input logic [1:0] code, input logic [7:0] data);
		pending_reqs.push_back('{code: code, data: data});
		total_reqs++;
	endtask

	// one message of random bytes, closed either by the last byte or by a bare finish,
	// with the odd unused code thrown in as noise
	task automatic add_message(input int unsigned msg_len);
		bit fin_with_byte;
		fin_with_byte = (msg_len != 0) && ($urandom_range(0, 1) == 1);
		for (int unsigned i = 0; i < msg_len; i++) begin
			if ($urandom_range(0, 99) < 4) add_req(CMD_UNUSED, 8'($urandom));
			add_req((fin_with_byte && i == msg_len - 1) ? CMD_APPEND_FIN : CMD_APPEND,
				8'($urandom));
		end
		if (!fin_with_byte) add_req(CMD_FINISH, 8'($urandom));
		msgs_queued++;
	endtask

	// periodic windows with no idling on either side
	function automatic bit quiet_window();
		return (cycle_count % 1500) < 300;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int unsigned idle_len();
		int unsigned r;
		if (quiet_window()) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 94) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ---------------------------------------------------------------------
	// driver: offers one request at a time, holds it while stalled
	// ---------------------------------------------------------------------

	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			absorb_request(cmd, data_byte);
			accepted_reqs++;
		end
		if (!in_valid || !in_stall) begin
			if (arst_n && send_gap == 0 && pending_reqs.size() != 0) begin
				next_req   = pending_reqs.pop_front();
				in_valid  <= 1'b1;
				cmd       <= next_req.code;
				data_byte <= next_req.data;
				send_gap   = idle_len();
			end else begin
				in_valid <= 1'b0;
				if (send_gap != 0) send_gap--;
			end
		end
	end

	// ---------------------------------------------------------------------
	// monitor: checks every accepted digest word, then picks the next stall
	// ---------------------------------------------------------------------

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			words_rcvd++;
			if (digest_due.size() == 0) begin
				$error("unexpected digest word %h (index %0d)", digest_word, word_index);
				mismatches++;
			end else begin
				due_word = digest_due.pop_front();
				if (digest_word !== due_word.word) begin
					$error("digest_word: expected %h, got %h", due_word.word, digest_word);
					mismatches++;
				end
				if (word_index !== due_word.index) begin
					$error("word_index: expected %0d, got %0d", due_word.index, word_index);
					mismatches++;
				end
				if (last_word !== due_word.is_last) begin
					$error("last_word: expected %0d, got %0d", due_word.is_last, last_word);
					mismatches++;
				end
			end
		end
		// a long hold-off overrides the random stalls
		if (hold_left != 0 || recv_gap != 0) begin
			out_stall <= 1'b1;
			if (recv_gap != 0) recv_gap--;
		end else begin
			out_stall <= 1'b0;
			recv_gap   = idle_len();
		end
	end

	// one long hold-off while a digest is on offer: the core has to stall its input
	// while the driver keeps offering requests
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && words_rcvd >= 10 && out_valid) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// test sequence
	// ---------------------------------------------------------------------

	initial begin
		int unsigned r;
		restart_message();

		// directed: empty message, the dropped code, "abc" with noise inside,
		// single-byte messages at both byte extremes, a bare finish carrying a stray byte
		add_req(CMD_FINISH, 8'h00);
		add_req(CMD_UNUSED, 8'hff);
		add_req(CMD_APPEND, 8'h61);
		add_req(CMD_APPEND, 8'h62);
		add_req(CMD_UNUSED, 8'h00);
		add_req(CMD_APPEND_FIN, 8'h63);
		add_req(CMD_APPEND_FIN, 8'hff);
		add_req(CMD_APPEND, 8'h00);
		add_req(CMD_FINISH, 8'h00);
		add_req(CMD_FINISH, 8'hff);
		add_req(CMD_UNUSED, 8'h5a);
		add_req(CMD_APPEND_FIN, 8'h00);

		// the longest message whose padding still fits in one block, and an exact full block
		add_message(55);
		add_message(64);

		// random messages, mostly short so digests come often
		while (total_reqs < 330 || msgs_queued < 15) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				add_message($urandom_range(0, 9));
			else if (r < 93)
				add_message($urandom_range(50, 70));
			else
				add_message($urandom_range(110, 135));
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (accepted_reqs < total_reqs) @(posedge clk);
		while (digest_due.size() != 0) @(posedge clk);
		// let any stray output show itself
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
